// ----- src/chd_pkg.sv -----
// Shared types, constants and helpers for the chunked body decoder.
`timescale 1ns / 1ps

package chd_pkg;

  // Default widths of the chunk size and payload total counters.
  localparam int SIZE_BITS_DEF  = 31;
  localparam int TOTAL_BITS_DEF = 32;
  localparam int MAX_BITS       = 32;

  // Reset value of the body size limit register.
  localparam logic [MAX_BITS-1:0] MAX_BODY_RESET = '1;

  // Special byte codes.
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // Decoder phases.
  typedef enum logic [2:0] {
    PH_WAIT = 3'd0,
    PH_HEX  = 3'd1,
    PH_SKIP = 3'd2,
    PH_LF   = 3'd3,
    PH_DATA = 3'd4,
    PH_HALT = 3'd5
  } phase_t;

  // Sticky error codes.
  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_LINE  = 2'd1,
    ERR_LARGE = 2'd2,
    ERR_EMPTY = 2'd3
  } err_t;

  // One input request.
  typedef struct packed {
    logic [7:0] body_byte;
    logic       start_body;
  } body_req_t;

  // One result request.
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       body_done;
    logic [1:0] error_code;
  } body_res_t;

  // Hex digit decode: bit 4 flags a hex digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h41 + 8'd10)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(c - 8'h61 + 8'd10)};
    end
    return r;
  endfunction

endpackage

// ----- src/chd_stream.sv -----
// Valid/ready channel interface carrying one payload type.
`timescale 1ns / 1ps

interface chd_stream #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/chd_input_stage.sv -----
// Input register stage: holds one body byte request until the decoder takes it.
`timescale 1ns / 1ps

module chd_input_stage (
  input  logic      clk,
  input  logic      rst,
  chd_stream.sink   req_in,
  chd_stream.source req_out
);
  import chd_pkg::*;

  logic      full;
  body_req_t held;
  logic      take;

  // The stage refills in the same cycle that its request moves on.
  assign take         = req_out.valid && req_out.ready;
  assign req_in.ready = !full || take;
  assign req_out.valid = full;
  assign req_out.data  = held;

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (req_in.valid && req_in.ready) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  // Payload capture.
  always_ff @(posedge clk) begin
    if (req_in.valid && req_in.ready) begin
      held <= req_in.data;
    end
  end

endmodule

// ----- src/chd_decoder.sv -----
// Chunked body parser state, next-state logic and result register.
`timescale 1ns / 1ps

module chd_decoder #(
  parameter int SIZE_BITS  = chd_pkg::SIZE_BITS_DEF,
  parameter int TOTAL_BITS = chd_pkg::TOTAL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [chd_pkg::MAX_BITS-1:0]  max_body,
  chd_stream.sink                       req_in,
  chd_stream.source                     res_out
);
  import chd_pkg::*;

  // Parser state registers.
  phase_t                phase, phase_next;
  logic [SIZE_BITS-1:0]  chunk_left, chunk_left_next;
  logic                  digit_seen, digit_seen_next;
  logic [TOTAL_BITS-1:0] payload_total, payload_total_next;
  err_t                  error_latch, error_latch_next;
  logic                  finished, finished_next;

  // State as seen by this byte, after an optional start of a new body.
  phase_t                c_phase;
  logic [SIZE_BITS-1:0]  c_left;
  logic                  c_seen;
  logic [TOTAL_BITS-1:0] c_total;
  err_t                  c_err;
  logic                  c_fin;

  logic                  res_valid;
  body_res_t             res, res_next;
  logic                  advance;
  logic [7:0]            c;
  logic [4:0]            hv;
  logic [MAX_BITS:0]     total_inc;
  logic                  too_large;
  logic                  size_full;
  logic                  pass;

  assign advance       = req_in.valid && (!res_valid || res_out.ready);
  assign req_in.ready  = !res_valid || res_out.ready;
  assign res_out.valid = res_valid;
  assign res_out.data  = res;

  assign c  = req_in.data.body_byte;
  assign hv = hex_value(c);

  // A start flag clears the body state before the byte is handled.
  always_comb begin
    if (req_in.data.start_body) begin
      c_phase = PH_WAIT;
      c_left  = '0;
      c_seen  = 1'b0;
      c_total = '0;
      c_err   = ERR_NONE;
      c_fin   = 1'b0;
    end else begin
      c_phase = phase;
      c_left  = chunk_left;
      c_seen  = digit_seen;
      c_total = payload_total;
      c_err   = error_latch;
      c_fin   = finished;
    end
  end

  // Overflow checks for the size digits and the payload total.
  assign size_full = |c_left[SIZE_BITS-1:SIZE_BITS-4];
  assign total_inc = (MAX_BITS+1)'(c_total) + 1'b1;
  assign too_large = (&c_total) || (total_inc > {1'b0, max_body});

  // Next-state logic for one byte.
  always_comb begin
    phase_next         = c_phase;
    chunk_left_next    = c_left;
    digit_seen_next    = c_seen;
    payload_total_next = c_total;
    error_latch_next   = c_err;
    finished_next      = c_fin;
    pass               = 1'b0;
    case (c_phase)
      PH_WAIT, PH_HEX: begin
        if (hv[4]) begin
          if (size_full) begin
            error_latch_next = ERR_LINE;
            phase_next       = PH_HALT;
          end else begin
            chunk_left_next = {c_left[SIZE_BITS-5:0], hv[3:0]};
            digit_seen_next = 1'b1;
            phase_next      = PH_HEX;
          end
        end else if (c_phase == PH_WAIT) begin
          if (c != CHAR_CR && c != CHAR_LF) begin
            phase_next = PH_SKIP;
          end
        end else if (c == CHAR_CR) begin
          phase_next = PH_LF;
        end else begin
          phase_next = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (c == CHAR_CR) begin
          phase_next = PH_LF;
        end
      end
      PH_LF: begin
        if (c == CHAR_LF) begin
          // End of the size line.
          digit_seen_next = 1'b0;
          if (!c_seen) begin
            error_latch_next = ERR_LINE;
            phase_next       = PH_HALT;
          end else if (c_left == '0) begin
            finished_next = 1'b1;
            phase_next    = PH_HALT;
            if (c_total == '0) begin
              error_latch_next = ERR_EMPTY;
            end
          end else begin
            phase_next = PH_DATA;
          end
        end else if (c != CHAR_CR) begin
          phase_next = PH_SKIP;
        end
      end
      PH_DATA: begin
        if (too_large) begin
          error_latch_next = ERR_LARGE;
          phase_next       = PH_HALT;
        end else begin
          pass               = 1'b1;
          payload_total_next = c_total + 1'b1;
          chunk_left_next    = c_left - 1'b1;
          if (c_left == SIZE_BITS'(1)) begin
            phase_next = PH_WAIT;
          end
        end
      end
      default: begin
        phase_next = PH_HALT;
      end
    endcase
  end

  // Result fields for this byte.
  always_comb begin
    res_next.payload_byte  = pass ? c : 8'd0;
    res_next.payload_valid = pass;
    res_next.body_done     = finished_next;
    res_next.error_code    = error_latch_next;
  end

  // State registers advance once per byte taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_WAIT;
      chunk_left    <= '0;
      digit_seen    <= 1'b0;
      payload_total <= '0;
      error_latch   <= ERR_NONE;
      finished      <= 1'b0;
    end else if (advance) begin
      phase         <= phase_next;
      chunk_left    <= chunk_left_next;
      digit_seen    <= digit_seen_next;
      payload_total <= payload_total_next;
      error_latch   <= error_latch_next;
      finished      <= finished_next;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res_out.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  // Any error or the end of the body always leaves the parser halted.
  a_halt_on_end: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_HALT) |-> (error_latch == ERR_NONE && !finished))
    else $error("error or end flag set outside the halted phase");

  // The payload phase always has bytes left to pass.
  a_data_left: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (chunk_left != '0))
    else $error("payload phase with no bytes left");

  // A passed byte never comes with an error or the end flag.
  a_clean_payload: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.payload_valid) |-> (res.error_code == ERR_NONE && !res.body_done))
    else $error("payload byte passed after end or error");

endmodule

// ----- src/http_chunked_body_decoder.sv -----
// Top level of the HTTP chunked body decoder.
`timescale 1ns / 1ps

// Usage:
//   body_in carries one raw body byte per request with a start_body flag that
//   clears the parser before that byte, so a new body begins with it.
//   result_out returns exactly one result request per input request, in order:
//   the byte when it is chunk payload, the end flag and the sticky error code.
//   cfg writes the body size limit (max payload bytes); it is always ready and
//   should be written only while no request is in flight.
// Timing:
//   Each request passes an input register and then the result register before
//   its result is offered. One request per cycle is sustained while result_out
//   is ready; the parser state updates once per byte taken.
// Reset:
//   rst (synchronous) empties both registers, clears the parser and sets the
//   limit to all ones.
// Backpressure:
//   When result_out is stalled the held result stays put, one more request is
//   taken into the input register, and body_in then drops ready.
module http_chunked_body_decoder #(
  parameter int SIZE_BITS  = chd_pkg::SIZE_BITS_DEF,
  parameter int TOTAL_BITS = chd_pkg::TOTAL_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  chd_stream.sink   body_in,
  chd_stream.source result_out,
  chd_stream.sink   cfg
);
  import chd_pkg::*;

  logic [MAX_BITS-1:0] max_body;

  chd_stream #(.T(body_req_t)) staged ();

  // The limit register takes every write at once.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_body <= MAX_BODY_RESET;
    end else if (cfg.valid) begin
      max_body <= MAX_BITS'(cfg.data);
    end
  end

  // Input register.
  chd_input_stage u_input (
    .clk     (clk),
    .rst     (rst),
    .req_in  (body_in),
    .req_out (staged)
  );

  // Parser and result register.
  chd_decoder #(
    .SIZE_BITS  (SIZE_BITS),
    .TOTAL_BITS (TOTAL_BITS)
  ) u_decoder (
    .clk      (clk),
    .rst      (rst),
    .max_body (max_body),
    .req_in   (staged),
    .res_out  (result_out)
  );

endmodule

// ----- tb/sv/tb_http_chunked_body_decoder.sv -----
// Self-checking testbench for the HTTP chunked body decoder.
`timescale 1ns / 1ps

module tb_http_chunked_body_decoder;
  import chd_pkg::*;

  localparam int SIZE_BITS  = SIZE_BITS_DEF;
  localparam int TOTAL_BITS = TOTAL_BITS_DEF;
  localparam logic [TOTAL_BITS:0] TOTAL_CAP = {1'b0, {TOTAL_BITS{1'b1}}};
  localparam int HOLD_CYCLES = 80;

  // Kinds of malformed input runs mixed in between proper bodies.
  typedef enum int {
    NOISE_OVERSIZE = 0,
    NOISE_NO_DIGIT = 1,
    NOISE_RANDOM   = 2
  } noise_t;

  logic clk;
  logic rst;

  chd_stream #(.T(body_req_t))              body_ch ();
  chd_stream #(.T(body_res_t))              result_ch ();
  chd_stream #(.T(logic [MAX_BITS-1:0]))    cfg_ch ();

  http_chunked_body_decoder #(
    .SIZE_BITS  (SIZE_BITS),
    .TOTAL_BITS (TOTAL_BITS)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .body_in    (body_ch),
    .result_out (result_ch),
    .cfg        (cfg_ch)
  );

  // Pending input bytes and the results predicted for accepted ones.
  body_req_t pend_q[$];
  body_res_t want_q[$];
  body_req_t cur_req;
  logic      offering;

  // Shadow copy of the parser state and the size limit.
  phase_t                parse_ph;
  logic [SIZE_BITS-1:0]  chunk_left;
  logic                  digit_seen;
  logic [TOTAL_BITS:0]   payload_total;
  err_t                  err_latch;
  logic                  body_finished;
  logic [MAX_BITS-1:0]   body_limit;

  int  send_idle_pct;
  int  recv_idle_pct;
  logic hold_off;
  logic stall_go;
  logic start_pending;
  logic counting;
  int  queued;
  int  bodies_queued;
  int  fail_count;
  int  checked_count;
  int  payload_seen;
  int  limits_written;

  // Clock with a 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Safety net against a hung handshake.
  initial begin
    #400000;
    $display("http_chunked_body_decoder verification failed");
    $finish;
  end

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s", msg);
    end
  endtask

  // Returns the value of a hex digit, or -1 for any other byte.
  function automatic int digit_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    return -1;
  endfunction

  task automatic clear_parser();
    parse_ph      = PH_WAIT;
    chunk_left    = '0;
    digit_seen    = 1'b0;
    payload_total = '0;
    err_latch     = ERR_NONE;
    body_finished = 1'b0;
  endtask

  // Shifts one digit into the chunk size, or flags an oversized size.
  task automatic take_digit(input logic [3:0] d);
    if ((chunk_left >> (SIZE_BITS - 4)) != 0) begin
      err_latch = ERR_LINE;
      parse_ph  = PH_HALT;
    end else begin
      chunk_left = {chunk_left[SIZE_BITS-5:0], d};
      digit_seen = 1'b1;
      parse_ph   = PH_HEX;
    end
  endtask

  // Advances the shadow parser by one byte and forms the expected result.
  task automatic advance_parser(input body_req_t req, output body_res_t res);
    int   hv;
    logic passed;
    hv     = digit_of(req.body_byte);
    passed = 1'b0;
    if (req.start_body) clear_parser();
    case (parse_ph)
      PH_WAIT: begin
        if (req.body_byte != CHAR_CR && req.body_byte != CHAR_LF) begin
          if (hv >= 0) take_digit(hv[3:0]);
          else parse_ph = PH_SKIP;
        end
      end
      PH_HEX: begin
        if (hv >= 0) take_digit(hv[3:0]);
        else if (req.body_byte == CHAR_CR) parse_ph = PH_LF;
        else parse_ph = PH_SKIP;
      end
      PH_SKIP: begin
        if (req.body_byte == CHAR_CR) parse_ph = PH_LF;
      end
      PH_LF: begin
        if (req.body_byte == CHAR_LF) begin
          // Only CR LF closes a size line.
          if (!digit_seen) begin
            err_latch = ERR_LINE;
            parse_ph  = PH_HALT;
          end else if (chunk_left == 0) begin
            body_finished = 1'b1;
            parse_ph      = PH_HALT;
            if (payload_total == 0) err_latch = ERR_EMPTY;
          end else begin
            parse_ph = PH_DATA;
          end
          digit_seen = 1'b0;
        end else if (req.body_byte != CHAR_CR) begin
          parse_ph = PH_SKIP;
        end
      end
      PH_DATA: begin
        if (payload_total >= TOTAL_CAP || (payload_total + 1'b1) > body_limit) begin
          err_latch = ERR_LARGE;
          parse_ph  = PH_HALT;
        end else begin
          payload_total = payload_total + 1'b1;
          passed        = 1'b1;
          chunk_left    = chunk_left - 1'b1;
          if (chunk_left == 0) parse_ph = PH_WAIT;
        end
      end
      default: begin
        parse_ph = PH_HALT;
      end
    endcase
    res.payload_byte  = passed ? req.body_byte : 8'h00;
    res.payload_valid = passed;
    res.body_done     = body_finished;
    res.error_code    = err_latch;
  endtask

  // Body driver: offers pending bytes and predicts each accepted request.
  always @(posedge clk) begin : drive_body
    body_res_t want;
    if (rst) begin
      body_ch.valid <= 1'b0;
      offering = 1'b0;
      want_q.delete();
      body_limit = MAX_BODY_RESET;
      clear_parser();
    end else begin
      if (offering && body_ch.ready) begin
        advance_parser(cur_req, want);
        want_q.push_back(want);
        offering = 1'b0;
      end
      if (!offering) begin
        if (pend_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = pend_q.pop_front();
          body_ch.data  <= cur_req;
          body_ch.valid <= 1'b1;
          offering = 1'b1;
        end else begin
          body_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each accepted result with the oldest prediction.
  always @(posedge clk) begin : check_results
    body_res_t exp_r;
    body_res_t got;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        got = result_ch.data;
        if (want_q.size() == 0) begin
          note_failure($sformatf("Unexpected result: byte %02h valid %0b done %0b err %0d",
                                 got.payload_byte, got.payload_valid, got.body_done,
                                 got.error_code));
        end else begin
          exp_r = want_q.pop_front();
          checked_count++;
          if (got.payload_valid) payload_seen++;
          if (got.payload_byte !== exp_r.payload_byte ||
              got.payload_valid !== exp_r.payload_valid ||
              got.body_done !== exp_r.body_done ||
              got.error_code !== exp_r.error_code) begin
            note_failure($sformatf(
              "Result %0d mismatch: byte %02h/%02h valid %0b/%0b done %0b/%0b err %0d/%0d",
              checked_count, exp_r.payload_byte, got.payload_byte, exp_r.payload_valid,
              got.payload_valid, exp_r.body_done, got.body_done, exp_r.error_code,
              got.error_code));
          end
        end
      end
      result_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Long receiver hold-off so that the decoder fills and stalls its input.
  initial begin : receiver_hold
    hold_off = 1'b0;
    wait (stall_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic queue_item(input logic [7:0] b);
    body_req_t r;
    r.body_byte  = b;
    r.start_body = start_pending;
    start_pending = 1'b0;
    pend_q.push_back(r);
    if (counting) queued++;
  endtask

  task automatic queue_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) queue_item(s[i]);
  endtask

  task automatic queue_crlf();
    queue_item(CHAR_CR);
    queue_item(CHAR_LF);
  endtask

  // Hex digit character with a random letter case.
  function automatic logic [7:0] hex_char(input int v);
    if (v < 10) return 8'(8'h30 + v);
    if ($urandom_range(1)) return 8'(8'h61 + v - 10);
    return 8'(8'h41 + v - 10);
  endfunction

  // Optional chunk extension: a semicolon and a few printable bytes.
  task automatic queue_extension();
    if ($urandom_range(3) == 0) begin
      queue_text(";");
      repeat ($urandom_range(1, 4)) queue_item(8'($urandom_range(8'h20, 8'h7e)));
    end
  endtask

  // One well-formed body with random chunk sizes and payload.
  task automatic queue_body();
    int sz;
    bodies_queued++;
    start_pending = 1'b1;
    if ($urandom_range(3) == 0) queue_crlf();
    repeat ($urandom_range(0, 3)) begin
      sz = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      repeat ($urandom_range(0, 2)) queue_text("0");
      if (sz >= 16) queue_item(hex_char(sz >> 4));
      queue_item(hex_char(sz & 15));
      queue_extension();
      queue_crlf();
      repeat (sz) queue_item(8'($urandom_range(255)));
      queue_crlf();
    end
    // Last chunk, then bytes the halted parser ignores.
    repeat ($urandom_range(1, 2)) queue_text("0");
    queue_extension();
    queue_crlf();
    counting = 1'b0;
    if ($urandom_range(2) == 0) queue_crlf();
    counting = 1'b1;
  endtask

  // A malformed run: oversized size, a line with no digit, or random bytes.
  task automatic queue_noise();
    noise_t kind;
    bodies_queued++;
    kind = noise_t'($urandom_range(2));
    start_pending = 1'b1;
    case (kind)
      NOISE_OVERSIZE: begin
        queue_item(hex_char($urandom_range(1, 15)));
        repeat (8) queue_item(hex_char($urandom_range(15)));
        counting = 1'b0;
        queue_crlf();
        counting = 1'b1;
      end
      NOISE_NO_DIGIT: begin
        queue_text(";");
        repeat ($urandom_range(0, 3)) queue_item(8'($urandom_range(8'h20, 8'h7e)));
        queue_crlf();
      end
      default: begin
        start_pending = 1'($urandom_range(1));
        repeat ($urandom_range(1, 10)) begin
          if ($urandom_range(3) == 0) start_pending = 1'b1;
          queue_item(8'($urandom_range(255)));
        end
      end
    endcase
  endtask

  task automatic queue_random(input int n);
    int target;
    target = queued + n;
    while (queued < target) begin
      if ($urandom_range(4) == 0) queue_noise();
      else queue_body();
    end
  endtask

  // Waits until every request has been taken and every result checked.
  task automatic wait_drained();
    do @(posedge clk);
    while (pend_q.size() != 0 || offering || want_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [MAX_BITS-1:0] v);
    @(posedge clk);
    cfg_ch.data  <= v;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    body_limit = v;
    limits_written++;
  endtask

  // Stimulus sequence: directed bytes, then random phases under several limits.
  initial begin : stimulus
    rst             = 1'b1;
    body_ch.valid   = 1'b0;
    body_ch.data    = '0;
    result_ch.ready = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.data     = '0;
    send_idle_pct   = 11;
    recv_idle_pct   = 86;
    stall_go        = 1'b0;
    start_pending   = 1'b0;
    counting        = 1'b1;
    queued          = 0;
    bodies_queued   = 0;
    fail_count      = 0;
    checked_count   = 0;
    payload_seen    = 0;
    limits_written  = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    write_limit(MAX_BODY_RESET);

    // Leading CR LF, lone LF and lone CR in an extension, extreme payload bytes.
    start_pending = 1'b1;
    queue_crlf();
    queue_text("3;");
    queue_item(CHAR_LF);
    queue_item(CHAR_CR);
    queue_text("x");
    queue_crlf();
    queue_item(8'h00);
    queue_item(8'hFF);
    queue_item(CHAR_CR);
    queue_text("0");
    queue_crlf();
    queue_item(8'hFF);
    // Size line without a digit.
    start_pending = 1'b1;
    queue_text(";");
    queue_crlf();
    // Zero-size chunk with no payload.
    start_pending = 1'b1;
    queue_text("0");
    queue_crlf();
    // Size that overflows the size field, mixed letter case.
    start_pending = 1'b1;
    queue_text("aBcDeF01");
    wait_drained();

    write_limit($urandom_range(8, 40));
    queue_random(200);
    wait_drained();

    send_idle_pct = 86;
    recv_idle_pct = 11;
    write_limit('0);
    queue_random(100);
    wait_drained();

    write_limit($urandom_range(1, 12));
    queue_random(150);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_limit(MAX_BODY_RESET);
    queue_random(150);
    stall_go = 1'b1;
    wait_drained();

    repeat (8) @(posedge clk);
    if (want_q.size() != 0) begin
      note_failure($sformatf("%0d predicted results never arrived", want_q.size()));
    end
    $display("Checked %0d results, %0d of them payload, from %0d bodies and noise runs.",
             checked_count, payload_seen, bodies_queued);
    $display("Size limit written %0d times, %0d mismatches counted.",
             limits_written, fail_count);
    if (fail_count == 0) begin
      $display("http_chunked_body_decoder verification clean");
    end else begin
      $display("http_chunked_body_decoder verification failed");
    end
    $finish;
  end

endmodule
